FILE: hdl/esc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the sensor compensation core and its divider.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [17:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
  } result_t;

  typedef struct packed {
    logic signed [17:0] temperature_centi;
    logic [16:0]        humidity_q22_10;
  } side_t;

  typedef struct packed {
    logic [63:0]        num;
    logic signed [30:0] den;
    side_t              side;
  } div_in_t;

  typedef struct packed {
    logic [63:0] quo;
    logic        neg;
    logic        den_ok;
    side_t       side;
  } div_out_t;

  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_HUM  = 3'd3,
    CFG_HUM        = 3'd4
  } cfg_reg_t;

  localparam logic signed [17:0] T_SAT_MAX    = 18'sh1FFFF;
  localparam logic signed [17:0] T_SAT_MIN    = 18'sh20000;
  localparam logic signed [24:0] P_OFFSET     = 25'sd128000;
  localparam logic [20:0]        P_BASE       = 21'd1048576;
  localparam logic [63:0]        P_SCALE      = 64'd3125;
  localparam logic signed [55:0] P_BIAS       = 56'sd140737488355328;
  localparam logic signed [24:0] H_OFFSET     = 25'sd76800;
  localparam logic signed [37:0] H_BIAS       = 38'sd2097152;
  localparam logic signed [63:0] H_MAX        = 64'sd419430400;

  localparam int DIV_NUM_W      = 64;
  localparam int DIV_DEN_W      = 31;
  localparam int DIV_DIGIT_BITS = 4;
  localparam int DIV_STAGES     = DIV_NUM_W / DIV_DIGIT_BITS;

  localparam int ESC_LATENCY    = 35;

endpackage
`default_nettype wire

FILE: hdl/esc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_divider
// Pipelined signed 64 by 31 bit divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module esc_divider
  import esc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire div_in_t  din,
  output logic          out_valid,
  output div_out_t      dout
);

  logic [DIV_STAGES:0]   vld;
  logic [DIV_NUM_W-1:0]  work [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0]  rem  [DIV_STAGES+1];
  logic [DIV_DEN_W-1:0]  dmag [DIV_STAGES+1];
  logic                  neg  [DIV_STAGES+1];
  logic                  ok   [DIV_STAGES+1];
  side_t                 side [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    work[0] <= din.num[DIV_NUM_W-1] ? (~din.num + 64'd1) : din.num;
    dmag[0] <= din.den[DIV_DEN_W-1] ? DIV_DEN_W'(-din.den) : din.den;
    rem[0]  <= '0;
    neg[0]  <= din.num[DIV_NUM_W-1] ^ din.den[DIV_DEN_W-1];
    ok[0]   <= (din.den != '0);
    side[0] <= din.side;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W-1:0] r;
    logic [DIV_NUM_W-1:0] w;

    always_comb begin
      r     = rem[k];
      w     = work[k];
      trial = '0;
      for (int i = 0; i < DIV_DIGIT_BITS; i++) begin
        trial = {r, w[DIV_NUM_W-1]};
        if (trial >= {1'b0, dmag[k]}) begin
          r = DIV_DEN_W'(trial - {1'b0, dmag[k]});
          w = {w[DIV_NUM_W-2:0], 1'b1};
        end else begin
          r = trial[DIV_DEN_W-1:0];
          w = {w[DIV_NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      work[k+1] <= w;
      rem[k+1]  <= r;
      dmag[k+1] <= dmag[k];
      neg[k+1]  <= neg[k];
      ok[k+1]   <= ok[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid   = vld[DIV_STAGES];
  assign dout.quo    = work[DIV_STAGES];
  assign dout.neg    = neg[DIV_STAGES];
  assign dout.den_ok = ok[DIV_STAGES];
  assign dout.side   = side[DIV_STAGES];

endmodule
`default_nettype wire

FILE: hdl/env_sensor_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// A reading is taken on any cycle with start high and busy low; busy is high
// only during reset. One reading per cycle is sustained. Each result appears
// for one cycle with done high, in input order; the receiver cannot hold it
// off. The pipeline holds the pressure divider: an input register and sixteen
// stages of four quotient bits each, between twelve stages of temperature,
// pressure and humidity arithmetic ahead and six behind.
// Calibration registers must be written only while no reading is in flight;
// the user is bound by this, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module env_sensor_compensation_core
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire sample_t     sample,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [47:0] press_hum_calib;
  logic [31:0] hum_calib;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_hum_calib  <= '0;
      hum_calib        <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TEMP:       temp_calib       <= cfg_data[47:0];
        CFG_PRESS_LOW:  press_calib_low  <= cfg_data;
        CFG_PRESS_HIGH: press_calib_high <= cfg_data;
        CFG_PRESS_HUM:  press_hum_calib  <= cfg_data[47:0];
        CFG_HUM:        hum_calib        <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_calib[15:0];
  assign t2 = $signed(temp_calib[31:16]);
  assign t3 = $signed(temp_calib[47:32]);
  assign p1 = press_calib_low[15:0];
  assign p2 = $signed(press_calib_low[31:16]);
  assign p3 = $signed(press_calib_low[47:32]);
  assign p4 = $signed(press_calib_low[63:48]);
  assign p5 = $signed(press_calib_high[15:0]);
  assign p6 = $signed(press_calib_high[31:16]);
  assign p7 = $signed(press_calib_high[47:32]);
  assign p8 = $signed(press_calib_high[63:48]);
  assign p9 = $signed(press_hum_calib[15:0]);
  assign h1 = press_hum_calib[23:16];
  assign h2 = $signed(press_hum_calib[39:24]);
  assign h3 = press_hum_calib[47:40];
  assign h4 = $signed(hum_calib[11:0]);
  assign h5 = $signed(hum_calib[23:12]);
  assign h6 = $signed(hum_calib[31:24]);

  assign busy = rst;

  logic [11:0] pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[10:0], start & ~busy};
    end
  end

  // stage 0: capture beat
  logic [19:0] s0_t, s0_p;
  logic [15:0] s0_h;

  always_ff @(posedge clk) begin
    s0_t <= sample.raw_temperature;
    s0_p <= sample.raw_pressure;
    s0_h <= sample.raw_humidity;
  end

  // stage 1
  logic signed [17:0] t_diff;
  logic signed [16:0] t_d;
  logic signed [33:0] s1_ta, s1_dd;
  logic [19:0]        s1_p;
  logic [15:0]        s1_h;

  assign t_diff = $signed({1'b0, s0_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign t_d    = $signed({1'b0, s0_t[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    s1_ta <= 34'(t_diff) * 34'(t2);
    s1_dd <= 34'(t_d) * 34'(t_d);
    s1_p  <= s0_p;
    s1_h  <= s0_h;
  end

  // stage 2
  logic signed [22:0] s2_ta;
  logic signed [37:0] s2_bt;
  logic [19:0]        s2_p;
  logic [15:0]        s2_h;

  always_ff @(posedge clk) begin
    s2_ta <= 23'(s1_ta >>> 11);
    s2_bt <= 38'(22'(s1_dd >>> 12)) * 38'(t3);
    s2_p  <= s1_p;
    s2_h  <= s1_h;
  end

  // stage 3: fine temperature
  logic signed [23:0] s3_fine;
  logic [19:0]        s3_p;
  logic [15:0]        s3_h;

  always_ff @(posedge clk) begin
    s3_fine <= 24'(s2_ta) + 24'(s2_bt >>> 14);
    s3_p    <= s2_p;
    s3_h    <= s2_h;
  end

  // stage 4
  logic signed [24:0] pa, hx;
  logic signed [26:0] tf;
  logic signed [18:0] t19;
  logic signed [17:0] t_sat;
  logic signed [49:0] s4_aa;
  logic signed [40:0] s4_ap5, s4_ap2;
  logic signed [36:0] s4_hx5;
  logic signed [32:0] s4_xh6;
  logic signed [33:0] s4_xh3;
  logic signed [17:0] s4_temp;
  logic [19:0]        s4_p;
  logic [15:0]        s4_h;

  assign pa  = 25'(s3_fine) - P_OFFSET;
  assign hx  = 25'(s3_fine) - H_OFFSET;
  assign tf  = (27'(s3_fine) <<< 2) + 27'(s3_fine) + 27'sd128;
  assign t19 = 19'(tf >>> 8);

  always_comb begin
    if (t19 > 19'(T_SAT_MAX)) begin
      t_sat = T_SAT_MAX;
    end else if (t19 < 19'(T_SAT_MIN)) begin
      t_sat = T_SAT_MIN;
    end else begin
      t_sat = t19[17:0];
    end
  end

  always_ff @(posedge clk) begin
    s4_aa   <= 50'(pa) * 50'(pa);
    s4_ap5  <= 41'(pa) * 41'(p5);
    s4_ap2  <= 41'(pa) * 41'(p2);
    s4_hx5  <= 37'(hx) * 37'(h5);
    s4_xh6  <= 33'(hx) * 33'(h6);
    s4_xh3  <= 34'(hx) * 34'($signed({1'b0, h3}));
    s4_temp <= t_sat;
    s4_p    <= s3_p;
    s4_h    <= s3_h;
  end

  // stage 5
  logic signed [65:0] aa_p6;
  logic signed [63:0] pb_sum;
  logic signed [39:0] hf_pre;
  logic signed [22:0] u6;
  logic signed [23:0] u3;
  logic signed [63:0] s5_pb;
  logic signed [65:0] s5_ca3;
  logic signed [40:0] s5_ap2;
  logic signed [19:0] s5_hf;
  logic signed [46:0] s5_gi;
  logic signed [17:0] s5_temp;
  logic [19:0]        s5_p;

  assign aa_p6  = 66'(s4_aa) * 66'(p6);
  assign pb_sum = 64'(aa_p6) + (64'(s4_ap5) <<< 17) + (64'(p4) <<< 35);
  assign hf_pre = 40'($signed({1'b0, s4_h, 14'd0})) - (40'(h4) <<< 20)
                  - 40'(s4_hx5) + 40'sd16384;
  assign u6     = 23'(s4_xh6 >>> 10);
  assign u3     = 24'(23'(s4_xh3 >>> 11)) + 24'sd32768;

  always_ff @(posedge clk) begin
    s5_pb   <= pb_sum;
    s5_ca3  <= 66'(s4_aa) * 66'(p3);
    s5_ap2  <= s4_ap2;
    s5_hf   <= 20'(hf_pre >>> 15);
    s5_gi   <= 47'(u6) * 47'(u3);
    s5_temp <= s4_temp;
    s5_p    <= s4_p;
  end

  // stage 6
  logic signed [37:0] gq;
  logic signed [55:0] s6_acc;
  logic signed [53:0] s6_gh;
  logic signed [63:0] s6_pb;
  logic signed [19:0] s6_hf;
  logic signed [17:0] s6_temp;
  logic [19:0]        s6_p;

  assign gq = 38'(s5_gi >>> 10) + H_BIAS;

  always_ff @(posedge clk) begin
    s6_acc  <= 56'(s5_ca3 >>> 8) + (56'(s5_ap2) <<< 12) + P_BIAS;
    s6_gh   <= 54'(gq) * 54'(h2);
    s6_pb   <= s5_pb;
    s6_hf   <= s5_hf;
    s6_temp <= s5_temp;
    s6_p    <= s5_p;
  end

  // stage 7
  logic [20:0]        pr21;
  logic signed [72:0] dp;
  logic [63:0]        s7_dp, s7_np;
  logic signed [30:0] s7_hg;
  logic signed [19:0] s7_hf;
  logic signed [17:0] s7_temp;

  assign pr21 = P_BASE - {1'b0, s6_p};
  assign dp   = 73'(s6_acc) * 73'($signed({1'b0, p1}));

  always_ff @(posedge clk) begin
    s7_dp   <= dp[63:0];
    s7_np   <= ({43'd0, pr21} << 31) - $unsigned(s6_pb);
    s7_hg   <= 31'((s6_gh + 54'sd8192) >>> 14);
    s7_hf   <= s6_hf;
    s7_temp <= s6_temp;
  end

  // stage 8: divisor, numerator, humidity product
  logic signed [30:0] s8_den;
  logic [63:0]        s8_num;
  logic signed [50:0] s8_hxf;
  logic signed [17:0] s8_temp;

  always_ff @(posedge clk) begin
    s8_den  <= 31'($signed(s7_dp) >>> 33);
    s8_num  <= s7_np * P_SCALE;
    s8_hxf  <= 51'(s7_hf) * 51'(s7_hg);
    s8_temp <= s7_temp;
  end

  // stage 9
  logic signed [35:0] ha;
  logic signed [71:0] sq;
  logic signed [63:0] s9_sq;
  logic signed [50:0] s9_hxf;
  logic [63:0]        s9_num;
  logic signed [30:0] s9_den;
  logic signed [17:0] s9_temp;

  assign ha = 36'(s8_hxf >>> 15);
  assign sq = 72'(ha) * 72'(ha);

  always_ff @(posedge clk) begin
    s9_sq   <= sq[63:0];
    s9_hxf  <= s8_hxf;
    s9_num  <= s8_num;
    s9_den  <= s8_den;
    s9_temp <= s8_temp;
  end

  // stage 10
  logic signed [56:0] sq7;
  logic signed [65:0] hs;
  logic signed [63:0] s10_hs;
  logic signed [50:0] s10_hxf;
  logic [63:0]        s10_num;
  logic signed [30:0] s10_den;
  logic signed [17:0] s10_temp;

  assign sq7 = 57'(s9_sq >>> 7);
  assign hs  = 66'(sq7) * 66'($signed({1'b0, h1}));

  always_ff @(posedge clk) begin
    s10_hs   <= hs[63:0];
    s10_hxf  <= s9_hxf;
    s10_num  <= s9_num;
    s10_den  <= s9_den;
    s10_temp <= s9_temp;
  end

  // stage 11: humidity clamp
  logic signed [63:0] hr;
  logic [28:0]        hc;
  logic [16:0]        s11_hum;
  logic [63:0]        s11_num;
  logic signed [30:0] s11_den;
  logic signed [17:0] s11_temp;

  assign hr = 64'(s10_hxf) - (s10_hs >>> 4);

  always_comb begin
    if (hr < 0) begin
      hc = '0;
    end else if (hr > H_MAX) begin
      hc = 29'(H_MAX);
    end else begin
      hc = hr[28:0];
    end
  end

  always_ff @(posedge clk) begin
    s11_hum  <= hc[28:12];
    s11_num  <= s10_num;
    s11_den  <= s10_den;
    s11_temp <= s10_temp;
  end

  // pressure divider
  div_in_t  div_in;
  div_out_t div_out;
  logic     div_valid;

  assign div_in.num                    = s11_num;
  assign div_in.den                    = s11_den;
  assign div_in.side.temperature_centi = s11_temp;
  assign div_in.side.humidity_q22_10   = s11_hum;

  esc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv[11]),
    .din       (div_in),
    .out_valid (div_valid),
    .dout      (div_out)
  );

  logic [4:0] pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp   <= '0;
      done <= 1'b0;
    end else begin
      pp   <= {pp[3:0], div_valid};
      done <= pp[4];
    end
  end

  // post 1: signed quotient
  logic [63:0] s12_q;
  logic        s12_ok;
  side_t       s12_side;

  always_ff @(posedge clk) begin
    s12_q    <= div_out.neg ? (~div_out.quo + 64'd1) : div_out.quo;
    s12_ok   <= div_out.den_ok;
    s12_side <= div_out.side;
  end

  // post 2
  logic signed [63:0] q13a;
  logic signed [66:0] t_full;
  logic [63:0]        s13_t;
  logic signed [48:0] s13_pl;
  logic signed [47:0] s13_ph;
  logic signed [63:0] s13_q;
  logic               s13_ok;
  side_t              s13_side;

  assign q13a   = $signed(s12_q) >>> 13;
  assign t_full = 67'(p9) * 67'(51'(q13a));

  always_ff @(posedge clk) begin
    s13_t    <= t_full[63:0];
    s13_pl   <= 49'($signed({1'b0, s12_q[31:0]})) * 49'(p8);
    s13_ph   <= 48'($signed(s12_q[63:32])) * 48'(p8);
    s13_q    <= $signed(s12_q);
    s13_ok   <= s12_ok;
    s13_side <= s12_side;
  end

  // post 3
  logic signed [63:0] q13b;
  logic signed [63:0] bsum;
  logic [63:0]        s14_m0;
  logic [31:0]        s14_m1, s14_m2;
  logic signed [63:0] s14_b2, s14_q;
  logic               s14_ok;
  side_t              s14_side;

  assign q13b = s13_q >>> 13;
  assign bsum = 64'(s13_pl) + (64'(s13_ph) <<< 32);

  always_ff @(posedge clk) begin
    s14_m0   <= 64'(s13_t[31:0]) * 64'(q13b[31:0]);
    s14_m1   <= s13_t[63:32] * q13b[31:0];
    s14_m2   <= s13_t[31:0] * q13b[63:32];
    s14_b2   <= bsum >>> 19;
    s14_q    <= s13_q;
    s14_ok   <= s13_ok;
    s14_side <= s13_side;
  end

  // post 4
  logic [63:0]        usum;
  logic signed [63:0] s15_a2, s15_b2, s15_q;
  logic               s15_ok;
  side_t              s15_side;

  assign usum = s14_m0 + {s14_m1 + s14_m2, 32'd0};

  always_ff @(posedge clk) begin
    s15_a2   <= $signed(usum) >>> 25;
    s15_b2   <= s14_b2;
    s15_q    <= s14_q;
    s15_ok   <= s14_ok;
    s15_side <= s14_side;
  end

  // post 5
  logic signed [63:0] s16_s;
  logic               s16_ok;
  side_t              s16_side;

  always_ff @(posedge clk) begin
    s16_s    <= s15_q + s15_a2 + s15_b2;
    s16_ok   <= s15_ok;
    s16_side <= s15_side;
  end

  // post 6: saturate and drive result
  logic signed [63:0] pr_fin;
  result_t            res_next;

  assign pr_fin = (s16_s >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    res_next.temperature_centi = s16_side.temperature_centi;
    res_next.humidity_q22_10   = s16_side.humidity_q22_10;
    res_next.pressure_valid    = s16_ok;
    if (!s16_ok || pr_fin < 0) begin
      res_next.pressure_q24_8 = '0;
    end else if (pr_fin > 64'sd4294967295) begin
      res_next.pressure_q24_8 = '1;
    end else begin
      res_next.pressure_q24_8 = pr_fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule
`default_nettype wire

FILE: hdl/esc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the sensor compensation core, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker
  import esc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ESC_LATENCY))
    else $error("result without a beat accepted at fixed latency");

  a_invalid_press_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.pressure_valid) |-> (result.pressure_q24_8 == 32'd0))
    else $error("pressure nonzero while flagged invalid");

  a_hum_clamped: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.humidity_q22_10 <= 17'd102400))
    else $error("humidity above full scale");

  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind env_sensor_compensation_core esc_checker u_chk (.*);
`default_nettype wire
